// File: hw/rtl/dsu_pkg.sv
// Shared constants for the disjoint-set union-find engine.
// No dependencies; used by disjoint_set_union_find.
`timescale 1ns / 1ps

package dsu_pkg;

  localparam int ELEMENTS_DEF = 1024;
  localparam int ELEM_W       = 10;
  localparam int RANK_W       = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

endpackage

// File: hw/rtl/disjoint_set_union_find.sv
// Union-find engine (union by rank, full path compression) over ELEMENTS nodes.
// An accepted start walks elem_a to its root and compresses that path, does the same
// for elem_b, then links the roots unless mode_i is set, and raises done_o; the parent
// RAM read-modify-write loop takes one node per cycle for the walk and again for
// compression. busy_o drops in the cycle done_o is high, so a new item may start then.
// After reset a pass clearing every entry holds busy_o high; done_o is never held off.
`timescale 1ns / 1ps

module disjoint_set_union_find #(
  parameter int ELEMENTS = dsu_pkg::ELEMENTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        mode_i,
  input  logic [dsu_pkg::ELEM_W-1:0]  elem_a_i,
  input  logic [dsu_pkg::ELEM_W-1:0]  elem_b_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic                        were_same_o,
  output logic [dsu_pkg::ELEM_W-1:0]  root_of_a_o
);

  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(ELEMENTS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WALK  = 5'b00100,
    S_COMP  = 5'b01000,
    S_LINK  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          phase_q, phase_d;
  logic          done_q, done_d;

  logic                       mode_q, mode_d;
  logic [AW-1:0]              b_q, b_d;
  logic [AW-1:0]              node_q, node_d;
  logic [AW-1:0]              origin_q, origin_d;
  logic [AW-1:0]              root_q, root_d;
  logic [AW-1:0]              ra_q, ra_d;
  logic [AW-1:0]              rb_q, rb_d;
  logic [dsu_pkg::RANK_W-1:0] rank_a_q, rank_a_d;
  logic [dsu_pkg::RANK_W-1:0] rank_b_q, rank_b_d;
  logic                       same_q, same_d;
  logic [dsu_pkg::ELEM_W-1:0] out_root_q, out_root_d;

  logic                       p_we;
  logic [AW-1:0]              p_waddr, p_wdata, p_raddr, p_rdata;
  logic                       r_we;
  logic [AW-1:0]              r_waddr;
  logic [dsu_pkg::RANK_W-1:0] r_wdata, r_rdata;
  logic [AW-1:0]              a_in, b_in;

  function automatic logic [AW-1:0] clamp_idx(input logic [dsu_pkg::ELEM_W-1:0] v);
    if (32'(v) >= ELEMENTS) begin
      clamp_idx = LAST_IDX;
    end else begin
      clamp_idx = AW'(v);
    end
  endfunction

  assign a_in = clamp_idx(elem_a_i);
  assign b_in = clamp_idx(elem_b_i);

  dsu_ram #(
    .WIDTH (AW),
    .DEPTH (ELEMENTS)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // Rank reads follow the parent read address, so a root's rank arrives with its link.
  dsu_ram #(
    .WIDTH (dsu_pkg::RANK_W),
    .DEPTH (ELEMENTS)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (p_raddr),
    .rdata_o (r_rdata)
  );

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    phase_d    = phase_q;
    done_d     = 1'b0;
    mode_d     = mode_q;
    b_d        = b_q;
    node_d     = node_q;
    origin_d   = origin_q;
    root_d     = root_q;
    ra_d       = ra_q;
    rb_d       = rb_q;
    rank_a_d   = rank_a_q;
    rank_b_d   = rank_b_q;
    same_d     = same_q;
    out_root_d = out_root_q;
    p_we       = 1'b0;
    p_waddr    = node_q;
    p_wdata    = root_q;
    p_raddr    = node_q;
    r_we       = 1'b0;
    r_waddr    = ra_q;
    r_wdata    = rank_a_q;

    case (state_q)
      S_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_q;
        p_wdata = clr_q;
        r_we    = 1'b1;
        r_waddr = clr_q;
        r_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          mode_d   = mode_i;
          b_d      = b_in;
          node_d   = a_in;
          origin_d = a_in;
          phase_d  = 1'b0;
          p_raddr  = a_in;
          state_d  = S_WALK;
        end
      end
      S_WALK: begin
        if (p_rdata == node_q) begin
          // Root reached: record it, then restart at the origin to compress.
          root_d = node_q;
          if (!phase_q) begin
            ra_d     = node_q;
            rank_a_d = r_rdata;
          end else begin
            rb_d     = node_q;
            rank_b_d = r_rdata;
          end
          node_d  = origin_q;
          p_raddr = origin_q;
          state_d = S_COMP;
        end else begin
          node_d  = p_rdata;
          p_raddr = p_rdata;
        end
      end
      S_COMP: begin
        if (node_q == root_q) begin
          if (!phase_q) begin
            phase_d  = 1'b1;
            node_d   = b_q;
            origin_d = b_q;
            p_raddr  = b_q;
            state_d  = S_WALK;
          end else begin
            state_d = S_LINK;
          end
        end else begin
          // Point this node at the root and advance along the old link.
          p_we    = 1'b1;
          p_waddr = node_q;
          p_wdata = root_q;
          node_d  = p_rdata;
          p_raddr = p_rdata;
        end
      end
      S_LINK: begin
        same_d     = (ra_q == rb_q);
        out_root_d = dsu_pkg::ELEM_W'(ra_q);
        if (!mode_q && (ra_q != rb_q)) begin
          if (rank_a_q < rank_b_q) begin
            p_we       = 1'b1;
            p_waddr    = ra_q;
            p_wdata    = rb_q;
            out_root_d = dsu_pkg::ELEM_W'(rb_q);
          end else begin
            p_we    = 1'b1;
            p_waddr = rb_q;
            p_wdata = ra_q;
            if ((rank_a_q == rank_b_q) && (rank_a_q < dsu_pkg::RANK_MAX)) begin
              r_we    = 1'b1;
              r_waddr = ra_q;
              r_wdata = rank_a_q + 1'b1;
            end
          end
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    b_q        <= b_d;
    node_q     <= node_d;
    origin_q   <= origin_d;
    root_q     <= root_d;
    ra_q       <= ra_d;
    rb_q       <= rb_d;
    rank_a_q   <= rank_a_d;
    rank_b_q   <= rank_b_d;
    same_q     <= same_d;
    out_root_q <= out_root_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign were_same_o = same_q;
  assign root_of_a_o = out_root_q;

  // A compression write must never hit the entry being read in the same cycle.
  a_comp_no_rw_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_we && (state_q == S_COMP)) |-> (p_waddr != p_raddr))
    else $error("parent RAM read and write collide during compression");

  // An accepted item keeps the block busy in the next cycle.
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  // A result strobe follows only from the link step.
  a_done_from_link : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == S_LINK))
    else $error("done strobe without a link step");

  // Ranks only change on the link step or the clearing pass, never during a walk or compression.
  a_rank_write_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_we |-> ((state_q == S_LINK) || (state_q == S_CLEAR)))
    else $error("rank write outside link or clear");

endmodule

// File: hw/rtl/dsu_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; holds the parent links and the ranks of dsu.
`timescale 1ns / 1ps

module dsu_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
